>>> hdl/mtwcc_pkg.sv
// Shared constants, codes, result type and helpers of the MESI two-way cache controller.
`default_nettype none

package mtwcc_pkg;

   // Default geometry
   localparam int unsigned SET_BITS_DEFAULT    = 4;
   localparam int unsigned OFFSET_BITS_DEFAULT = 5;
   localparam int unsigned ADDR_BITS_DEFAULT   = 32;

   // Request operation codes
   localparam logic [2:0] OP_READ        = 3'd0;
   localparam logic [2:0] OP_WRITE       = 3'd1;
   localparam logic [2:0] OP_SNOOP_RD    = 3'd2;
   localparam logic [2:0] OP_SNOOP_RDX   = 3'd3;
   localparam logic [2:0] OP_SNOOP_UPGR  = 3'd4;
   localparam logic [2:0] OP_SNOOP_FLUSH = 3'd5;
   localparam logic [2:0] OP_FLUSH_ALL   = 3'd6;

   // MESI line states
   localparam logic [1:0] ST_I = 2'd0;
   localparam logic [1:0] ST_S = 2'd1;
   localparam logic [1:0] ST_E = 2'd2;
   localparam logic [1:0] ST_M = 2'd3;

   // Bus commands
   localparam logic [1:0] BUS_NONE = 2'd0;
   localparam logic [1:0] BUS_RD   = 2'd1;
   localparam logic [1:0] BUS_RDX  = 2'd2;
   localparam logic [1:0] BUS_UPGR = 2'd3;

   // One result beat
   typedef struct packed {
      logic        hit;
      logic        way;
      logic [1:0]  bus_command;
      logic        fill_request;
      logic        writeback_request;
      logic [31:0] writeback_address;
      logic [1:0]  line_state;
      logic        snoop_copy;
      logic        supplied_data;
      logic        last;
   } rsp_type;

   // Rebuild a block address from tag and set, cut to 32 bits
   function automatic logic [31:0] block_address(input logic [63:0] tag,
                                                 input logic [63:0] set,
                                                 input int unsigned idx_shift,
                                                 input int unsigned off_bits);
      logic [63:0] addr;
      addr = (tag << idx_shift) | (set << off_bits);
      return addr[31:0];
   endfunction

endpackage

`default_nettype wire

>>> hdl/mtwcc_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module mtwcc_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one word, register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hdl/mtwcc_update.sv
// Set update logic: hit check, victim choice and MESI transition for one access.
`default_nettype none

module mtwcc_update #(
   parameter int unsigned SET_BITS    = mtwcc_pkg::SET_BITS_DEFAULT,
   parameter int unsigned OFFSET_BITS = mtwcc_pkg::OFFSET_BITS_DEFAULT,
   parameter int unsigned ADDR_BITS   = mtwcc_pkg::ADDR_BITS_DEFAULT,
   localparam int unsigned IDX_SHIFT  = OFFSET_BITS + SET_BITS,
   localparam int unsigned TAG_BITS   = ADDR_BITS - IDX_SHIFT,
   localparam int unsigned WAY_W      = TAG_BITS + 3,
   localparam int unsigned ROW_W      = 2 * WAY_W
) (
   input  wire logic [2:0]          op,
   input  wire logic [TAG_BITS-1:0] tag,
   input  wire logic [SET_BITS-1:0] set_idx,
   input  wire logic [31:0]         base,
   input  wire logic                others_have_copy,
   input  wire logic [ROW_W-1:0]    row,
   output      logic [ROW_W-1:0]    new_row,
   output      mtwcc_pkg::rsp_type  rsp
);

   logic [TAG_BITS-1:0] tag_w  [2];
   logic [1:0]          st_w   [2];
   logic                rc_w   [2];
   logic [TAG_BITS-1:0] ntag_w [2];
   logic [1:0]          nst_w  [2];
   logic                nrc_w  [2];
   logic                hit0;
   logic                hit1;
   logic                hit;
   logic                hway;
   logic                victim;
   logic                wb;
   logic [1:0]          ns;
   logic [1:0]          cur;

   // Unpack the set row and compute the new row and the result
   always_comb begin
      for (int w = 0; w < 2; w++) begin
         tag_w[w]  = row[w*WAY_W+3 +: TAG_BITS];
         st_w[w]   = row[w*WAY_W+1 +: 2];
         rc_w[w]   = row[w*WAY_W];
         ntag_w[w] = tag_w[w];
         nst_w[w]  = st_w[w];
         nrc_w[w]  = rc_w[w];
      end

      hit0   = (st_w[0] != mtwcc_pkg::ST_I) && (tag_w[0] == tag);
      hit1   = (st_w[1] != mtwcc_pkg::ST_I) && (tag_w[1] == tag);
      hit    = hit0 | hit1;
      hway   = ~hit0;
      victim = rc_w[0] & ~rc_w[1];
      wb     = 1'b0;
      ns     = mtwcc_pkg::ST_I;
      cur    = st_w[hway];

      rsp      = '0;
      rsp.last = 1'b1;

      unique case (op) inside
         mtwcc_pkg::OP_READ, mtwcc_pkg::OP_WRITE: begin
            if (hit) begin
               nrc_w[hway]  = 1'b1;
               nrc_w[~hway] = 1'b0;
               rsp.hit      = 1'b1;
               rsp.way      = hway;
               if (op == mtwcc_pkg::OP_WRITE) begin
                  nst_w[hway]     = mtwcc_pkg::ST_M;
                  rsp.line_state  = mtwcc_pkg::ST_M;
                  rsp.bus_command = (cur == mtwcc_pkg::ST_S) ? mtwcc_pkg::BUS_UPGR
                                                             : mtwcc_pkg::BUS_NONE;
               end else begin
                  rsp.line_state = cur;
               end
            end else begin
               // Evict the victim, write it back if dirty, fill with the new block
               if (op == mtwcc_pkg::OP_WRITE) begin
                  ns              = mtwcc_pkg::ST_M;
                  rsp.bus_command = mtwcc_pkg::BUS_RDX;
               end else begin
                  ns              = others_have_copy ? mtwcc_pkg::ST_S : mtwcc_pkg::ST_E;
                  rsp.bus_command = mtwcc_pkg::BUS_RD;
               end
               wb                    = (st_w[victim] == mtwcc_pkg::ST_M);
               rsp.way               = victim;
               rsp.fill_request      = 1'b1;
               rsp.writeback_request = wb;
               rsp.writeback_address = wb ? mtwcc_pkg::block_address(64'(tag_w[victim]),
                                               64'(set_idx), IDX_SHIFT, OFFSET_BITS)
                                          : 32'd0;
               rsp.line_state        = ns;
               nst_w[victim]         = ns;
               ntag_w[victim]        = tag;
               nrc_w[victim]         = 1'b1;
               nrc_w[~victim]        = 1'b0;
            end
         end
         mtwcc_pkg::OP_SNOOP_RD, mtwcc_pkg::OP_SNOOP_RDX,
         mtwcc_pkg::OP_SNOOP_UPGR, mtwcc_pkg::OP_SNOOP_FLUSH: begin
            if (hit) begin
               ns = cur;
               if (op == mtwcc_pkg::OP_SNOOP_RD) begin
                  wb = (cur == mtwcc_pkg::ST_M);
                  if (cur == mtwcc_pkg::ST_M || cur == mtwcc_pkg::ST_E) begin
                     ns = mtwcc_pkg::ST_S;
                  end
               end else if (op == mtwcc_pkg::OP_SNOOP_RDX) begin
                  wb = (cur == mtwcc_pkg::ST_M);
                  ns = mtwcc_pkg::ST_I;
               end else if (op == mtwcc_pkg::OP_SNOOP_UPGR) begin
                  if (cur == mtwcc_pkg::ST_S || cur == mtwcc_pkg::ST_E) begin
                     ns = mtwcc_pkg::ST_I;
                  end
               end
               nst_w[hway]           = ns;
               rsp.hit               = 1'b1;
               rsp.way               = hway;
               rsp.snoop_copy        = 1'b1;
               rsp.writeback_request = wb;
               rsp.supplied_data     = wb;
               rsp.writeback_address = wb ? base : 32'd0;
               rsp.line_state        = ns;
            end
         end
         default: begin
         end
      endcase

      for (int w = 0; w < 2; w++) begin
         new_row[w*WAY_W+3 +: TAG_BITS] = ntag_w[w];
         new_row[w*WAY_W+1 +: 2]        = nst_w[w];
         new_row[w*WAY_W]               = nrc_w[w];
      end
   end

endmodule

`default_nettype wire

>>> hdl/mesi_two_way_cache_controller.sv
// Top level of the MESI two-way cache controller: set RAM, sequencer and result register.
//
//  channel | direction | handshake           | payload
//  req_    | in        | req_valid/req_stall | op, address, others_have_copy
//  rsp_    | out       | rsp_valid/rsp_stall | hit .. last, one port per field
//
// Read, write and snoop beats read the set RAM, then update the row and write it back.
// Flush all walks each set row one way a cycle, unless a dirty line waits on a stalled result.
// Reset clears one valid bit per set row; a row not yet written reads as all Invalid.
// A stalled result holds the sequencer only when a new result must be loaded.
`default_nettype none

module mesi_two_way_cache_controller #(
   parameter int unsigned SET_BITS    = mtwcc_pkg::SET_BITS_DEFAULT,
   parameter int unsigned OFFSET_BITS = mtwcc_pkg::OFFSET_BITS_DEFAULT,
   parameter int unsigned ADDR_BITS   = mtwcc_pkg::ADDR_BITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [2:0]  req_op,
   input  wire logic [31:0] req_address,
   input  wire logic        req_others_have_copy,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic        rsp_hit,
   output      logic        rsp_way,
   output      logic [1:0]  rsp_bus_command,
   output      logic        rsp_fill_request,
   output      logic        rsp_writeback_request,
   output      logic [31:0] rsp_writeback_address,
   output      logic [1:0]  rsp_line_state,
   output      logic        rsp_snoop_copy,
   output      logic        rsp_supplied_data,
   output      logic        rsp_last
);

   localparam int unsigned NSETS     = 1 << SET_BITS;
   localparam int unsigned IDX_SHIFT = OFFSET_BITS + SET_BITS;
   localparam int unsigned TAG_BITS  = ADDR_BITS - IDX_SHIFT;
   localparam int unsigned WAY_W     = TAG_BITS + 3;
   localparam int unsigned ROW_W     = 2 * WAY_W;
   localparam logic [63:0] ADDR_MASK = (ADDR_BITS >= 64) ? {64{1'b1}}
                                       : ((64'd1 << ADDR_BITS) - 64'd1);
   localparam logic [31:0] OFF_MASK  = 32'((64'd1 << OFFSET_BITS) - 64'd1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOKUP,
      S_FLUSH,
      S_END
   } state_type;

   state_type             state_ff, state_in;
   logic [2:0]            op_ff, op_in;
   logic [TAG_BITS-1:0]   tag_ff, tag_in;
   logic [SET_BITS-1:0]   set_ff, set_in;
   logic [31:0]           base_ff, base_in;
   logic                  others_ff, others_in;
   logic                  way_ff, way_in;
   logic [NSETS-1:0]      valid_ff, valid_in;
   logic                  held_valid_ff, held_valid_in;
   logic                  held_way_ff, held_way_in;
   logic [31:0]           held_wba_ff, held_wba_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   mtwcc_pkg::rsp_type    rsp_ff, rsp_in;

   logic                  accept;
   logic                  out_free;
   logic                  push;
   logic [63:0]           addr_full;
   logic [SET_BITS-1:0]   req_set;
   logic [TAG_BITS-1:0]   req_tag;
   logic                  rd_en;
   logic [SET_BITS-1:0]   rd_addr;
   logic                  wr_en;
   logic [ROW_W-1:0]      wr_data;
   logic [ROW_W-1:0]      rd_data;
   logic [ROW_W-1:0]      row_eff;
   logic [ROW_W-1:0]      upd_row;
   logic [ROW_W-1:0]      flush_row;
   mtwcc_pkg::rsp_type    upd_rsp;
   logic [1:0]            fl_state;
   logic [TAG_BITS-1:0]   fl_tag;
   logic                  fl_dirty;

   // Split the request address
   assign addr_full = {32'd0, req_address} & ADDR_MASK;
   assign req_set   = addr_full[OFFSET_BITS +: SET_BITS];
   assign req_tag   = addr_full[ADDR_BITS-1:IDX_SHIFT];

   assign accept    = req_valid && (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Rows never written read as all Invalid
   assign row_eff = valid_ff[set_ff] ? rd_data : '0;

   // Line seen by the flush walk
   assign fl_state = row_eff[way_ff*WAY_W+1 +: 2];
   assign fl_tag   = row_eff[way_ff*WAY_W+3 +: TAG_BITS];
   assign fl_dirty = (fl_state == mtwcc_pkg::ST_M);

   // Demote every Modified line of the row to Exclusive
   always_comb begin
      flush_row = row_eff;
      for (int w = 0; w < 2; w++) begin
         if (row_eff[w*WAY_W+1 +: 2] == mtwcc_pkg::ST_M) begin
            flush_row[w*WAY_W+1 +: 2] = mtwcc_pkg::ST_E;
         end
      end
   end

   mtwcc_ram #(
      .WIDTH (ROW_W),
      .DEPTH (NSETS)
   ) u_set_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (set_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mtwcc_update #(
      .SET_BITS    (SET_BITS),
      .OFFSET_BITS (OFFSET_BITS),
      .ADDR_BITS   (ADDR_BITS)
   ) u_update (
      .op               (op_ff),
      .tag              (tag_ff),
      .set_idx          (set_ff),
      .base             (base_ff),
      .others_have_copy (others_ff),
      .row              (row_eff),
      .new_row          (upd_row),
      .rsp              (upd_rsp)
   );

   // Sequence lookups and the flush walk
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      tag_in        = tag_ff;
      set_in        = set_ff;
      base_in       = base_ff;
      others_in     = others_ff;
      way_in        = way_ff;
      valid_in      = valid_ff;
      held_valid_in = held_valid_ff;
      held_way_in   = held_way_ff;
      held_wba_in   = held_wba_ff;
      rsp_in        = rsp_ff;
      push          = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = req_set;
      wr_en         = 1'b0;
      wr_data       = upd_row;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in     = req_op;
               tag_in    = req_tag;
               base_in   = addr_full[31:0] & ~OFF_MASK;
               others_in = req_others_have_copy;
               way_in    = 1'b0;
               rd_en     = 1'b1;
               if (req_op == mtwcc_pkg::OP_FLUSH_ALL) begin
                  rd_addr  = '0;
                  set_in   = '0;
                  state_in = S_FLUSH;
               end else begin
                  set_in   = req_set;
                  state_in = S_LOOKUP;
               end
            end
         end
         S_LOOKUP: begin
            if (out_free) begin
               wr_en            = 1'b1;
               valid_in[set_ff] = 1'b1;
               push             = 1'b1;
               rsp_in           = upd_rsp;
               state_in         = S_IDLE;
            end
         end
         S_FLUSH: begin
            // Hold while a dirty line must displace a held result that cannot leave
            if (!(fl_dirty && held_valid_ff && !out_free)) begin
               if (fl_dirty) begin
                  if (held_valid_ff) begin
                     push                     = 1'b1;
                     rsp_in                   = '0;
                     rsp_in.way               = held_way_ff;
                     rsp_in.writeback_request = 1'b1;
                     rsp_in.writeback_address = held_wba_ff;
                     rsp_in.line_state        = mtwcc_pkg::ST_E;
                  end
                  held_valid_in = 1'b1;
                  held_way_in   = way_ff;
                  held_wba_in   = mtwcc_pkg::block_address(64'(fl_tag), 64'(set_ff),
                                                           IDX_SHIFT, OFFSET_BITS);
               end
               if (way_ff) begin
                  wr_en            = 1'b1;
                  wr_data          = flush_row;
                  valid_in[set_ff] = 1'b1;
                  way_in           = 1'b0;
                  if (set_ff == {SET_BITS{1'b1}}) begin
                     state_in = S_END;
                  end else begin
                     set_in   = SET_BITS'(set_ff + 1'b1);
                     rd_addr  = SET_BITS'(set_ff + 1'b1);
                     rd_en    = 1'b1;
                  end
               end else begin
                  way_in = 1'b1;
               end
            end
         end
         S_END: begin
            if (out_free) begin
               push   = 1'b1;
               rsp_in = '0;
               if (held_valid_ff) begin
                  rsp_in.way               = held_way_ff;
                  rsp_in.writeback_request = 1'b1;
                  rsp_in.writeback_address = held_wba_ff;
                  rsp_in.line_state        = mtwcc_pkg::ST_E;
               end
               rsp_in.last   = 1'b1;
               held_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Load a new result beat, or drop the one taken
      if (push) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Hold state, control and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         valid_ff      <= '0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      op_ff       <= op_in;
      tag_ff      <= tag_in;
      set_ff      <= set_in;
      base_ff     <= base_in;
      others_ff   <= others_in;
      way_ff      <= way_in;
      held_way_ff <= held_way_in;
      held_wba_ff <= held_wba_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_hit               = rsp_ff.hit;
   assign rsp_way               = rsp_ff.way;
   assign rsp_bus_command       = rsp_ff.bus_command;
   assign rsp_fill_request      = rsp_ff.fill_request;
   assign rsp_writeback_request = rsp_ff.writeback_request;
   assign rsp_writeback_address = rsp_ff.writeback_address;
   assign rsp_line_state        = rsp_ff.line_state;
   assign rsp_snoop_copy        = rsp_ff.snoop_copy;
   assign rsp_supplied_data     = rsp_ff.supplied_data;
   assign rsp_last              = rsp_ff.last;

   // Never overwrite a result beat that is still stalled
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      push && rsp_valid_ff |-> !rsp_stall)
      else $error("result beat overwritten while stalled");

   // A lookup beat goes to the update cycle right after the RAM read
   a_lookup_follows: assert property (@(posedge clock) disable iff (reset)
      accept && (req_op != mtwcc_pkg::OP_FLUSH_ALL) |=> state_ff == S_LOOKUP)
      else $error("lookup did not follow accepted beat");

   // A held flush result exists only during the flush walk
   a_held_in_flush: assert property (@(posedge clock) disable iff (reset)
      held_valid_ff |-> (state_ff == S_FLUSH) || (state_ff == S_END))
      else $error("held flush result outside flush walk");

   // The set RAM is written only by an update or the flush walk
   a_write_busy: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_LOOKUP) || (state_ff == S_FLUSH))
      else $error("set RAM written while idle");

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking testbench of the MESI two-way cache controller with its own line predictor.
`timescale 1ns / 100ps

module tb;

   localparam int OFF_W       = mtwcc_pkg::OFFSET_BITS_DEFAULT;
   localparam int SET_W       = mtwcc_pkg::SET_BITS_DEFAULT;
   localparam int SETS        = 1 << SET_W;
   localparam int TAG_W       = 32 - OFF_W - SET_W;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = 2 * SETS + 8;
   localparam int RANDOM_ITEMS = 250;

   // Opcode that the block leaves unused
   localparam logic [2:0] OP_UNUSED = 3'd7;

   localparam mtwcc_pkg::rsp_type NO_RSP    = '0;
   localparam mtwcc_pkg::rsp_type EMPTY_RSP = '{1'b0, 1'b0, mtwcc_pkg::BUS_NONE, 1'b0, 1'b0,
                                                32'h0, mtwcc_pkg::ST_I, 1'b0, 1'b0, 1'b1};

   typedef struct packed {
      logic [2:0]         op;
      logic [31:0]        addr;
      logic               others;
      logic               typed;
      mtwcc_pkg::rsp_type want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_op = mtwcc_pkg::OP_READ;
   logic [31:0] req_address = '0;
   logic        req_others_have_copy = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_hit;
   logic        rsp_way;
   logic [1:0]  rsp_bus_command;
   logic        rsp_fill_request;
   logic        rsp_writeback_request;
   logic [31:0] rsp_writeback_address;
   logic [1:0]  rsp_line_state;
   logic        rsp_snoop_copy;
   logic        rsp_supplied_data;
   logic        rsp_last;

   // Predicted line arrays
   logic [TAG_W-1:0] line_tag    [SETS][2];
   logic [1:0]       line_mesi   [SETS][2];
   logic             line_recent [SETS][2];

   mtwcc_pkg::rsp_type pending_rsp[$];
   int      mismatches = 0;
   int      rsp_beats = 0;
   int      cycles = 0;
   int      burst_left = 0;
   int      stall_left = 0;
   int      stall_mode = 0;
   int      stall_phase = 0;

   logic [TAG_W-1:0] tag_pool [SETS][3];

   // Directed rows: typed expectations where they are plain, predictor elsewhere
   stim_row_type directed_rows [0:24] = '{
      '{mtwcc_pkg::OP_READ,        32'h0000_0000, 1'b0, 1'b1,
        '{1'b0, 1'b0, mtwcc_pkg::BUS_RD, 1'b1, 1'b0, 32'h0, mtwcc_pkg::ST_E,
          1'b0, 1'b0, 1'b1}},
      '{mtwcc_pkg::OP_FLUSH_ALL,   32'h0000_0000, 1'b0, 1'b1, EMPTY_RSP},
      '{mtwcc_pkg::OP_SNOOP_RD,    32'hFFFF_FFFF, 1'b0, 1'b1, EMPTY_RSP},
      '{mtwcc_pkg::OP_WRITE,       32'hFFFF_FFFF, 1'b1, 1'b1,
        '{1'b0, 1'b0, mtwcc_pkg::BUS_RDX, 1'b1, 1'b0, 32'h0, mtwcc_pkg::ST_M,
          1'b0, 1'b0, 1'b1}},
      '{mtwcc_pkg::OP_READ,        32'hFFFF_FFE0, 1'b0, 1'b1,
        '{1'b1, 1'b0, mtwcc_pkg::BUS_NONE, 1'b0, 1'b0, 32'h0, mtwcc_pkg::ST_M,
          1'b0, 1'b0, 1'b1}},
      '{mtwcc_pkg::OP_WRITE,       32'h0000_0004, 1'b0, 1'b1,
        '{1'b1, 1'b0, mtwcc_pkg::BUS_NONE, 1'b0, 1'b0, 32'h0, mtwcc_pkg::ST_M,
          1'b0, 1'b0, 1'b1}},
      '{mtwcc_pkg::OP_READ,        32'h0000_0200, 1'b1, 1'b1,
        '{1'b0, 1'b1, mtwcc_pkg::BUS_RD, 1'b1, 1'b0, 32'h0, mtwcc_pkg::ST_S,
          1'b0, 1'b0, 1'b1}},
      '{mtwcc_pkg::OP_WRITE,       32'h0000_021F, 1'b0, 1'b1,
        '{1'b1, 1'b1, mtwcc_pkg::BUS_UPGR, 1'b0, 1'b0, 32'h0, mtwcc_pkg::ST_M,
          1'b0, 1'b0, 1'b1}},
      '{mtwcc_pkg::OP_READ,        32'h0000_0400, 1'b0, 1'b0, NO_RSP},
      '{mtwcc_pkg::OP_SNOOP_RD,    32'h0000_0210, 1'b0, 1'b0, NO_RSP},
      '{mtwcc_pkg::OP_SNOOP_UPGR,  32'h0000_0200, 1'b0, 1'b0, NO_RSP},
      '{mtwcc_pkg::OP_SNOOP_FLUSH, 32'h0000_0400, 1'b0, 1'b0, NO_RSP},
      '{mtwcc_pkg::OP_SNOOP_UPGR,  32'h0000_0400, 1'b0, 1'b0, NO_RSP},
      '{mtwcc_pkg::OP_WRITE,       32'h0000_0800, 1'b0, 1'b0, NO_RSP},
      '{mtwcc_pkg::OP_SNOOP_UPGR,  32'h0000_0800, 1'b0, 1'b0, NO_RSP},
      '{mtwcc_pkg::OP_SNOOP_RDX,   32'h0000_0800, 1'b0, 1'b0, NO_RSP},
      '{mtwcc_pkg::OP_READ,        32'h1234_5660, 1'b0, 1'b0, NO_RSP},
      '{mtwcc_pkg::OP_SNOOP_RD,    32'h1234_5660, 1'b0, 1'b0, NO_RSP},
      '{mtwcc_pkg::OP_WRITE,       32'h8000_0020, 1'b0, 1'b0, NO_RSP},
      '{mtwcc_pkg::OP_WRITE,       32'h7FFF_FFC0, 1'b1, 1'b0, NO_RSP},
      '{mtwcc_pkg::OP_FLUSH_ALL,   32'h0000_0000, 1'b0, 1'b0, NO_RSP},
      '{OP_UNUSED,                 32'hA5A5_A5A5, 1'b1, 1'b1, EMPTY_RSP},
      '{mtwcc_pkg::OP_FLUSH_ALL,   32'hFFFF_FFFF, 1'b1, 1'b1, EMPTY_RSP},
      '{mtwcc_pkg::OP_SNOOP_RDX,   32'h8000_0020, 1'b0, 1'b0, NO_RSP},
      '{mtwcc_pkg::OP_SNOOP_FLUSH, 32'h0000_1000, 1'b0, 1'b0, NO_RSP}
   };

   mesi_two_way_cache_controller dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_op                (req_op),
      .req_address           (req_address),
      .req_others_have_copy  (req_others_have_copy),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_hit               (rsp_hit),
      .rsp_way               (rsp_way),
      .rsp_bus_command       (rsp_bus_command),
      .rsp_fill_request      (rsp_fill_request),
      .rsp_writeback_request (rsp_writeback_request),
      .rsp_writeback_address (rsp_writeback_address),
      .rsp_line_state        (rsp_line_state),
      .rsp_snoop_copy        (rsp_snoop_copy),
      .rsp_supplied_data     (rsp_supplied_data),
      .rsp_last              (rsp_last)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Print one mismatch line and count it
   task automatic report_mismatch(input string msg);
      $display("mismatch at result beat %0d: %s", rsp_beats, msg);
      mismatches++;
   endtask

   // Advance the line arrays by one request and queue the result beats it causes
   function automatic void predict_response(input logic [2:0] op, input logic [31:0] addr,
                                            input logic others);
      logic [SET_W-1:0]   set;
      logic [TAG_W-1:0]   tag;
      logic               found;
      logic               hw;
      logic               victim;
      logic [1:0]         mesi;
      mtwcc_pkg::rsp_type r;
      int                 n;
      int                 w;
      int                 s;
      set   = addr[OFF_W +: SET_W];
      tag   = addr[31 -: TAG_W];
      found = 1'b0;
      hw    = 1'b0;
      r     = EMPTY_RSP;
      n     = 0;
      for (w = 1; w >= 0; w--) begin
         if (line_mesi[set][w] != mtwcc_pkg::ST_I && line_tag[set][w] == tag) begin
            found = 1'b1;
            hw    = w[0];
         end
      end
      case (op) inside
         mtwcc_pkg::OP_READ, mtwcc_pkg::OP_WRITE: begin
            if (found) begin
               r.hit = 1'b1;
               r.way = hw;
               if (op == mtwcc_pkg::OP_WRITE) begin
                  r.bus_command = (line_mesi[set][hw] == mtwcc_pkg::ST_S) ?
                                  mtwcc_pkg::BUS_UPGR : mtwcc_pkg::BUS_NONE;
                  line_mesi[set][hw] = mtwcc_pkg::ST_M;
               end
               r.line_state = line_mesi[set][hw];
               line_recent[set][hw]  = 1'b1;
               line_recent[set][!hw] = 1'b0;
            end else begin
               // Evict the least recent way, way 0 on a tie
               victim = line_recent[set][0] & ~line_recent[set][1];
               if (line_mesi[set][victim] == mtwcc_pkg::ST_M) begin
                  r.writeback_request = 1'b1;
                  r.writeback_address = {line_tag[set][victim], set, {OFF_W{1'b0}}};
               end
               if (op == mtwcc_pkg::OP_WRITE) begin
                  mesi = mtwcc_pkg::ST_M;
                  r.bus_command = mtwcc_pkg::BUS_RDX;
               end else begin
                  mesi = others ? mtwcc_pkg::ST_S : mtwcc_pkg::ST_E;
                  r.bus_command = mtwcc_pkg::BUS_RD;
               end
               line_mesi[set][victim]    = mesi;
               line_tag[set][victim]     = tag;
               line_recent[set][victim]  = 1'b1;
               line_recent[set][!victim] = 1'b0;
               r.way          = victim;
               r.fill_request = 1'b1;
               r.line_state   = mesi;
            end
            pending_rsp = {pending_rsp, r};
         end
         mtwcc_pkg::OP_SNOOP_RD, mtwcc_pkg::OP_SNOOP_RDX,
         mtwcc_pkg::OP_SNOOP_UPGR, mtwcc_pkg::OP_SNOOP_FLUSH: begin
            if (found) begin
               mesi = line_mesi[set][hw];
               r.hit = 1'b1;
               r.way = hw;
               r.snoop_copy = 1'b1;
               if ((op == mtwcc_pkg::OP_SNOOP_RD || op == mtwcc_pkg::OP_SNOOP_RDX) &&
                   mesi == mtwcc_pkg::ST_M) begin
                  r.writeback_request = 1'b1;
                  r.supplied_data     = 1'b1;
                  r.writeback_address = {addr[31:OFF_W], {OFF_W{1'b0}}};
               end
               case (op)
                  mtwcc_pkg::OP_SNOOP_RD:
                     if (mesi == mtwcc_pkg::ST_M || mesi == mtwcc_pkg::ST_E)
                        mesi = mtwcc_pkg::ST_S;
                  mtwcc_pkg::OP_SNOOP_RDX:
                     mesi = mtwcc_pkg::ST_I;
                  mtwcc_pkg::OP_SNOOP_UPGR:
                     if (mesi == mtwcc_pkg::ST_S || mesi == mtwcc_pkg::ST_E)
                        mesi = mtwcc_pkg::ST_I;
                  default: ;
               endcase
               line_mesi[set][hw] = mesi;
               r.line_state = mesi;
            end
            pending_rsp = {pending_rsp, r};
         end
         mtwcc_pkg::OP_FLUSH_ALL: begin
            // Walk set by set, way 0 first; clean every dirty line to Exclusive
            for (s = 0; s < SETS; s++) begin
               for (w = 0; w < 2; w++) begin
                  if (line_mesi[s][w] == mtwcc_pkg::ST_M) begin
                     line_mesi[s][w] = mtwcc_pkg::ST_E;
                     r = NO_RSP;
                     r.way = w[0];
                     r.writeback_request = 1'b1;
                     r.writeback_address = {line_tag[s][w], s[SET_W-1:0], {OFF_W{1'b0}}};
                     r.line_state = mtwcc_pkg::ST_E;
                     pending_rsp = {pending_rsp, r};
                     n++;
                  end
               end
            end
            if (n == 0) pending_rsp = {pending_rsp, EMPTY_RSP};
            else pending_rsp[pending_rsp.size() - 1].last = 1'b1;
         end
         default: pending_rsp = {pending_rsp, EMPTY_RSP};
      endcase
   endfunction

   // Present one request beat in bursts with random gaps, hold it until taken
   task automatic send_beat(input logic [2:0] op, input logic [31:0] addr, input logic others,
                            input logic typed, input mtwcc_pkg::rsp_type want);
      int gap;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 6);
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(1, 12);
      end
      req_valid            <= 1'b1;
      req_op               <= op;
      req_address          <= addr;
      req_others_have_copy <= others;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
      predict_response(op, addr, others);
      if (typed) begin
         pending_rsp[pending_rsp.size() - 1] = want;
      end
   endtask

   // Receiver stall pattern: calm, light, heavy and periodic stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
         end
         stall_left--;
         stall_phase++;
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 9) < 7);
            default: rsp_stall <= ((stall_phase % 5) < 2);
         endcase
      end
   end

   // Compare every accepted result beat with the oldest prediction
   always @(posedge clock) begin
      mtwcc_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("result beat with nothing pending");
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_hit !== want.hit)
               report_mismatch($sformatf("hit got %0h want %0h", rsp_hit, want.hit));
            if (rsp_way !== want.way)
               report_mismatch($sformatf("way got %0h want %0h", rsp_way, want.way));
            if (rsp_bus_command !== want.bus_command)
               report_mismatch($sformatf("bus_command got %0h want %0h",
                                         rsp_bus_command, want.bus_command));
            if (rsp_fill_request !== want.fill_request)
               report_mismatch($sformatf("fill_request got %0h want %0h",
                                         rsp_fill_request, want.fill_request));
            if (rsp_writeback_request !== want.writeback_request)
               report_mismatch($sformatf("writeback_request got %0h want %0h",
                                         rsp_writeback_request, want.writeback_request));
            if (rsp_writeback_address !== want.writeback_address)
               report_mismatch($sformatf("writeback_address got %h want %h",
                                         rsp_writeback_address, want.writeback_address));
            if (rsp_line_state !== want.line_state)
               report_mismatch($sformatf("line_state got %0h want %0h",
                                         rsp_line_state, want.line_state));
            if (rsp_snoop_copy !== want.snoop_copy)
               report_mismatch($sformatf("snoop_copy got %0h want %0h",
                                         rsp_snoop_copy, want.snoop_copy));
            if (rsp_supplied_data !== want.supplied_data)
               report_mismatch($sformatf("supplied_data got %0h want %0h",
                                         rsp_supplied_data, want.supplied_data));
            if (rsp_last !== want.last)
               report_mismatch($sformatf("last got %0h want %0h", rsp_last, want.last));
         end
         rsp_beats++;
      end
   end

   // Drop the run at the cycle limit
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycles, pending_rsp.size());
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      int          i;
      int          s;
      int          k;
      int          pick;
      logic [2:0]  op;
      logic [31:0] addr;
      logic [SET_W-1:0] set;

      // Clear the predicted arrays to their reset contents
      for (s = 0; s < SETS; s++) begin
         for (k = 0; k < 2; k++) begin
            line_tag[s][k]    = '0;
            line_mesi[s][k]   = mtwcc_pkg::ST_I;
            line_recent[s][k] = 1'b0;
         end
      end

      // Hold reset, then release it
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table
      for (i = 0; i < $size(directed_rows); i++) begin
         send_beat(directed_rows[i].op, directed_rows[i].addr, directed_rows[i].others,
                   directed_rows[i].typed, directed_rows[i].want);
      end

      // Few tags per set so that hits, evictions and snoop matches are common
      for (s = 0; s < SETS; s++) begin
         tag_pool[s][0] = TAG_W'($urandom);
         tag_pool[s][1] = (s % 2) ? '1 : '0;
         tag_pool[s][2] = TAG_W'($urandom);
      end

      for (i = 0; i < RANDOM_ITEMS; i++) begin
         // Midway, dirty every line and flush them all for the longest result train
         if (i == RANDOM_ITEMS / 2) begin
            for (s = 0; s < SETS; s++) begin
               for (k = 0; k < 2; k++) begin
                  send_beat(mtwcc_pkg::OP_WRITE, {tag_pool[s][k], s[SET_W-1:0],
                                                  OFF_W'($urandom)},
                            1'($urandom_range(0, 1)), 1'b0, NO_RSP);
               end
            end
            send_beat(mtwcc_pkg::OP_FLUSH_ALL, $urandom, 1'($urandom_range(0, 1)), 1'b0,
                      NO_RSP);
         end
         pick = $urandom_range(0, 99);
         if (pick < 30)      op = mtwcc_pkg::OP_READ;
         else if (pick < 55) op = mtwcc_pkg::OP_WRITE;
         else if (pick < 65) op = mtwcc_pkg::OP_SNOOP_RD;
         else if (pick < 73) op = mtwcc_pkg::OP_SNOOP_RDX;
         else if (pick < 81) op = mtwcc_pkg::OP_SNOOP_UPGR;
         else if (pick < 88) op = mtwcc_pkg::OP_SNOOP_FLUSH;
         else if (pick < 95) op = mtwcc_pkg::OP_FLUSH_ALL;
         else if (pick < 97) op = OP_UNUSED;
         else                op = mtwcc_pkg::OP_READ;
         if ($urandom_range(0, 9) == 0) begin
            addr = $urandom;
         end else begin
            set  = SET_W'($urandom_range(0, SETS - 1));
            addr = {tag_pool[set][$urandom_range(0, 2)], set, OFF_W'($urandom)};
         end
         send_beat(op, addr, 1'($urandom_range(0, 1)), 1'b0, NO_RSP);
      end
      req_valid <= 1'b0;

      // Wait out the remaining results, then allow a full flush walk for strays
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
